@@ hw/rtl/bbea_pkg.sv @@
// ----------------------------------------------------------------------------
// Bark band energy analyzer package
// Shared widths, register indexes and the band edge and weight tables.
// ----------------------------------------------------------------------------
package bbea_pkg;

    localparam int BAND_COUNT   = 24;
    localparam int BAND_W       = 5;
    localparam int MAX_FFT_SIZE = 8192;
    localparam int RATE_W       = 18;
    localparam int FFT_W        = 14;
    localparam int CNT_W        = 13;
    localparam int FSUM_W       = 31;
    localparam int ENERGY_W     = 48;
    localparam int POW_W        = 32;
    localparam int ROOT_W       = ENERGY_W / 2;
    localparam int MAG_W        = 24;
    localparam int EDGE_W       = 14;
    localparam int COEF_W       = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 18;

    localparam logic [BAND_W-1:0] TOP_BAND = BAND_W'(BAND_COUNT - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [FFT_W-1:0]  FFT_LIMIT = FFT_W'(MAX_FFT_SIZE);

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FFT_SIZE    = 2'd1;

    function automatic logic [EDGE_W-1:0] band_edge(input logic [BAND_W-1:0] band);
        logic [EDGE_W-1:0] edge_hz;
        case (band)
            5'd0:    edge_hz = 14'd100;
            5'd1:    edge_hz = 14'd200;
            5'd2:    edge_hz = 14'd300;
            5'd3:    edge_hz = 14'd400;
            5'd4:    edge_hz = 14'd510;
            5'd5:    edge_hz = 14'd630;
            5'd6:    edge_hz = 14'd770;
            5'd7:    edge_hz = 14'd920;
            5'd8:    edge_hz = 14'd1080;
            5'd9:    edge_hz = 14'd1270;
            5'd10:   edge_hz = 14'd1480;
            5'd11:   edge_hz = 14'd1720;
            5'd12:   edge_hz = 14'd2000;
            5'd13:   edge_hz = 14'd2320;
            5'd14:   edge_hz = 14'd2700;
            5'd15:   edge_hz = 14'd3150;
            5'd16:   edge_hz = 14'd3700;
            5'd17:   edge_hz = 14'd4400;
            5'd18:   edge_hz = 14'd5300;
            5'd19:   edge_hz = 14'd6400;
            5'd20:   edge_hz = 14'd7700;
            5'd21:   edge_hz = 14'd9500;
            5'd22:   edge_hz = 14'd12000;
            default: edge_hz = 14'd15500;
        endcase
        return edge_hz;
    endfunction

    function automatic logic [COEF_W-1:0] band_coef(input logic [BAND_W-1:0] band);
        logic [COEF_W-1:0] coef;
        case (band)
            5'd0:    coef = 17'd53971;
            5'd1:    coef = 17'd58814;
            5'd2:    coef = 17'd60362;
            5'd3:    coef = 17'd60362;
            5'd4:    coef = 17'd60362;
            5'd5:    coef = 17'd60127;
            5'd6:    coef = 17'd59043;
            5'd7:    coef = 17'd57633;
            5'd8:    coef = 17'd57460;
            5'd9:    coef = 17'd57736;
            5'd10:   coef = 17'd58041;
            5'd11:   coef = 17'd58734;
            5'd12:   coef = 17'd59578;
            5'd13:   coef = 17'd61124;
            5'd14:   coef = 17'd62861;
            5'd15:   coef = 17'd64456;
            5'd16:   coef = 17'd65536;
            5'd17:   coef = 17'd63840;
            5'd18:   coef = 17'd60816;
            5'd19:   coef = 17'd56687;
            5'd20:   coef = 17'd53724;
            5'd21:   coef = 17'd53657;
            5'd22:   coef = 17'd48290;
            default: coef = 17'd41204;
        endcase
        return coef;
    endfunction

endpackage

@@ hw/rtl/bbea_isqrt.sv @@
// ----------------------------------------------------------------------------
// Bark band energy analyzer square root unit
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module bbea_isqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bbea_pkg::ENERGY_W-1:0]     radicand,
    output logic                              done,
    output logic [bbea_pkg::ROOT_W-1:0]       root
);

    localparam int REM_W = bbea_pkg::ROOT_W + 2;
    localparam int STEP_W = $clog2(bbea_pkg::ROOT_W + 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                          state_reg, state_next;
    logic [bbea_pkg::ENERGY_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]                rem_reg, rem_next;
    logic [bbea_pkg::ROOT_W-1:0]     root_reg, root_next;
    logic [STEP_W-1:0]               step_reg, step_next;
    logic                            done_reg, done_next;

    logic [REM_W+1:0]                rem_shift;
    logic [REM_W+1:0]                trial;

    assign rem_shift = {rem_reg, rad_reg[bbea_pkg::ENERGY_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        state_next = state_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rad_next   = radicand;
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                rad_next = {rad_reg[bbea_pkg::ENERGY_W-3:0], 2'b00};
                if (rem_shift >= trial)
                begin
                    rem_next  = REM_W'(rem_shift - trial);
                    root_next = {root_reg[bbea_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(rem_shift);
                    root_next = {root_reg[bbea_pkg::ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(bbea_pkg::ROOT_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_RUN))
        else $error("square root finished without running");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |=> (state_reg == S_RUN) || done_reg)
        else $error("square root left run state early");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(bbea_pkg::ROOT_W))
        else $error("square root step count out of range");

endmodule

@@ hw/rtl/bark_band_energy_analyzer_top.sv @@
// ----------------------------------------------------------------------------
// Bark band energy analyzer
// A new bin word is accepted only once the last one is done; each bin runs
// through one shared multiplier for the band edge, re*re and im*im, then a saturating add.
// At frame end each of the 24 bands runs the root, wait and emit states in turn,
// with the 24-step square root unit working in the wait state; a frame with a
// count error or overflow instead gives a single error word marked last.
// Reset clears all frame state and loads 44100 Hz and a 1024-point size.
// ----------------------------------------------------------------------------
module bark_band_energy_analyzer_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbea_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbea_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,    // bin_real, bin_imag
    input  logic                                s_tlast,    // frame_last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,    // band_number, band_magnitude
    output logic                                m_tuser,    // frame_error
    output logic                                m_tlast     // result_last
);

    localparam int PROD_W = 43;
    localparam int MULR_W = 40;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_SQ_RE,
        S_SQ_IM,
        S_ACC,
        S_ERR,
        S_ROOT,
        S_WAIT,
        S_EMIT
    } state_t;

    state_t                                  state_reg, state_next;
    logic [bbea_pkg::RATE_W-1:0]             rate_reg, rate_next;
    logic [bbea_pkg::FFT_W-1:0]              fft_reg, fft_next;
    logic [bbea_pkg::CNT_W-1:0]              cnt_reg, cnt_next;
    logic [bbea_pkg::FSUM_W-1:0]             fsum_reg, fsum_next;
    logic [bbea_pkg::BAND_W-1:0]             band_reg, band_next;
    logic                                    ovf_reg, ovf_next;
    logic [bbea_pkg::BAND_W-1:0]             k_reg, k_next;
    logic                                    m_tvalid_reg, m_tvalid_next;
    logic [31:0]                             m_tdata_reg, m_tdata_next;
    logic                                    m_tuser_reg, m_tuser_next;
    logic                                    m_tlast_reg, m_tlast_next;

    logic signed [15:0]                      re_reg, re_next;
    logic signed [15:0]                      im_reg, im_next;
    logic                                    last_reg, last_next;
    logic [bbea_pkg::POW_W-1:0]              pow_reg, pow_next;
    logic [MULR_W-1:0]                       mul_reg, mul_next;

    logic [bbea_pkg::ENERGY_W-1:0]           energy_reg [bbea_pkg::BAND_COUNT];
    logic                                    energy_we;
    logic                                    energy_clr;
    logic [bbea_pkg::ENERGY_W:0]             energy_sum;
    logic [bbea_pkg::ENERGY_W-1:0]           energy_wdata;

    logic signed [24:0]                      mul_a;
    logic signed [17:0]                      mul_b;
    logic signed [PROD_W-1:0]                mul_p;

    logic [bbea_pkg::FFT_W-1:0]              size;
    logic [bbea_pkg::FFT_W-1:0]              expected;
    logic [bbea_pkg::FFT_W-1:0]              total;
    logic [bbea_pkg::FSUM_W:0]               fsum_add;
    logic                                    out_free;

    logic                                    sq_start;
    logic                                    sq_done;
    logic [bbea_pkg::ROOT_W-1:0]             sq_root;

    bbea_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (energy_reg[k_reg]),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign size     = (fft_reg > bbea_pkg::FFT_LIMIT) ? bbea_pkg::FFT_LIMIT : fft_reg;
    assign expected = {1'b0, size[bbea_pkg::FFT_W-1:1]} + 1'b1;
    assign total    = {1'b0, cnt_reg} + 1'b1;
    assign fsum_add = {1'b0, fsum_reg} + (bbea_pkg::FSUM_W + 1)'(rate_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    assign energy_sum   = {1'b0, energy_reg[band_reg]} + (bbea_pkg::ENERGY_W + 1)'(pow_reg);
    assign energy_wdata = energy_sum[bbea_pkg::ENERGY_W] ? {bbea_pkg::ENERGY_W{1'b1}}
                                                         : energy_sum[bbea_pkg::ENERGY_W-1:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_EDGE:
            begin
                mul_a = {11'b0, size};
                mul_b = {4'b0, bbea_pkg::band_edge(band_reg)};
            end
            S_SQ_RE:
            begin
                mul_a = {{9{re_reg[15]}}, re_reg};
                mul_b = {{2{re_reg[15]}}, re_reg};
            end
            S_SQ_IM:
            begin
                mul_a = {{9{im_reg[15]}}, im_reg};
                mul_b = {{2{im_reg[15]}}, im_reg};
            end
            S_WAIT:
            begin
                mul_a = {1'b0, sq_root};
                mul_b = {1'b0, bbea_pkg::band_coef(k_reg)};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next    = state_reg;
        rate_next     = rate_reg;
        fft_next      = fft_reg;
        cnt_next      = cnt_reg;
        fsum_next     = fsum_reg;
        band_next     = band_reg;
        ovf_next      = ovf_reg;
        k_next        = k_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        re_next       = re_reg;
        im_next       = im_reg;
        last_next     = last_reg;
        pow_next      = pow_reg;
        mul_next      = mul_reg;
        energy_we     = 1'b0;
        energy_clr    = 1'b0;
        sq_start      = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                bbea_pkg::REG_SAMPLE_RATE: rate_next = cfg_data;
                bbea_pkg::REG_FFT_SIZE:    fft_next  = cfg_data[bbea_pkg::FFT_W-1:0];
                default:                   ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    re_next    = s_tdata[15:0];
                    im_next    = s_tdata[31:16];
                    last_next  = s_tlast;
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                mul_next   = mul_p[MULR_W-1:0];
                state_next = S_SQ_RE;
            end
            S_SQ_RE:
            begin
                if (band_reg < bbea_pkg::TOP_BAND && {9'b0, fsum_reg} >= mul_reg)
                begin
                    band_next = band_reg + 1'b1;
                end
                pow_next   = mul_p[bbea_pkg::POW_W-1:0];
                state_next = S_SQ_IM;
            end
            S_SQ_IM:
            begin
                pow_next   = pow_reg + mul_p[bbea_pkg::POW_W-1:0];
                state_next = S_ACC;
            end
            S_ACC:
            begin
                energy_we = 1'b1;
                if (!last_reg)
                begin
                    if (cnt_reg == bbea_pkg::CNT_MAX)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    fsum_next  = fsum_add[bbea_pkg::FSUM_W] ? {bbea_pkg::FSUM_W{1'b1}}
                                                             : fsum_add[bbea_pkg::FSUM_W-1:0];
                    state_next = S_IDLE;
                end
                else if (ovf_reg || total != expected)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_ROOT;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b1;
                    energy_clr    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ROOT:
            begin
                sq_start   = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sq_done)
                begin
                    mul_next   = mul_p[MULR_W-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b0, mul_reg[MULR_W-1:16], k_reg};
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = (k_reg == bbea_pkg::TOP_BAND);
                    if (k_reg == bbea_pkg::TOP_BAND)
                    begin
                        energy_clr = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_ROOT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (energy_clr)
        begin
            cnt_next  = '0;
            fsum_next = '0;
            band_next = '0;
            ovf_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rate_reg     <= 18'd44100;
            fft_reg      <= 14'd1024;
            cnt_reg      <= '0;
            fsum_reg     <= '0;
            band_reg     <= '0;
            ovf_reg      <= 1'b0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rate_reg     <= rate_next;
            fft_reg      <= fft_next;
            cnt_reg      <= cnt_next;
            fsum_reg     <= fsum_next;
            band_reg     <= band_next;
            ovf_reg      <= ovf_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
        re_reg      <= re_next;
        im_reg      <= im_next;
        last_reg    <= last_next;
        pow_reg     <= pow_next;
        mul_reg     <= mul_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bbea_pkg::BAND_COUNT; i++)
            begin
                energy_reg[i] <= '0;
            end
        end
        else if (energy_clr)
        begin
            for (int i = 0; i < bbea_pkg::BAND_COUNT; i++)
            begin
                energy_reg[i] <= '0;
            end
        end
        else if (energy_we)
        begin
            energy_reg[band_reg] <= energy_wdata;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        band_reg <= bbea_pkg::TOP_BAND)
        else $error("band index beyond the top band");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_EDGE))
        else $error("accepted bin did not start processing");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("error word not marked last");

    a_last_band: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && !m_tuser) |-> (m_tdata[4:0] == bbea_pkg::TOP_BAND))
        else $error("last word of a frame is not the top band");

    a_root_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_WAIT))
        else $error("square root result arrived outside the wait state");

endmodule
